[hw/rtl/rc_frame_parser_core_assert.svh]
// assertion macros for the frame parser
`ifndef RC_FRAME_PARSER_CORE_ASSERT_SVH
`define RC_FRAME_PARSER_CORE_ASSERT_SVH

// condition holds in the same cycle
`define RCFP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the following cycle
`define RCFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/rcfp_pkg.sv]
package rcfp_pkg;

	localparam int MAX_FRAME_LEN = 255;
	localparam int NUM_CHANNELS  = 10;
	localparam int HELD_DEPTH    = 10;
	localparam int CHAN_W        = 16;
	localparam int POS_W         = $clog2(MAX_FRAME_LEN + 1);

	localparam logic [7:0] HDR0    = 8'hAA;
	localparam logic [7:0] HDR1    = 8'hAF;
	localparam logic [7:0] FUNC_RC = 8'h03;

	localparam int MIN_LEN    = 6;
	localparam int MIN_RC_LEN = 28;
	localparam int CHAN_BASE  = 4;
	localparam int CHAN_END   = CHAN_BASE + 2 * NUM_CHANNELS;

	localparam int OUT_W       = 3 + HELD_DEPTH * CHAN_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		STAT_UPDATED    = 3'd0,
		STAT_BAD_HEADER = 3'd1,
		STAT_BAD_SUM    = 3'd2,
		STAT_OTHER_FUNC = 3'd3,
		STAT_TOO_SHORT  = 3'd4
	} status_t;

	typedef logic [HELD_DEPTH-1:0][CHAN_W-1:0] chan_arr_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             hdr_ok;
		logic [7:0]       func;
		logic [31:0]      sum_nxt;
		logic [31:0]      tail_nxt;
	} trk_t;

endpackage

[hw/rtl/rcfp_track.sv]
module rcfp_track import rcfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] data_in,
	input  logic       last_in,
	output trk_t       trk,
	output chan_arr_t  staged
);

	logic [POS_W-1:0] pos_q;
	logic             hdr_ok_q;
	logic [7:0]       func_q;
	logic [31:0]      sum_q;
	logic [31:0]      tail_q;
	chan_arr_t        staged_q;

	logic [POS_W-1:0] pos_nxt;
	logic [POS_W-1:0] chan_off;
	logic [POS_W-2:0] chan_idx;
	logic             chan_wr;

	always_comb begin
		trk.pos      = pos_q;
		trk.hdr_ok   = hdr_ok_q;
		trk.func     = func_q;
		trk.sum_nxt  = (pos_q >= POS_W'(CHAN_BASE)) ? sum_q + {24'd0, tail_q[31:24]} : sum_q;
		trk.tail_nxt = {tail_q[23:0], data_in};
		pos_nxt      = (pos_q >= POS_W'(MAX_FRAME_LEN - 1)) ? POS_W'(MAX_FRAME_LEN)
			: pos_q + POS_W'(1);
		chan_off     = pos_q - POS_W'(CHAN_BASE);
		chan_idx     = chan_off[POS_W-1:1];
		chan_wr      = (pos_q >= POS_W'(CHAN_BASE)) && (pos_q < POS_W'(CHAN_END));
	end

	assign staged = staged_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hdr_ok_q <= 1'b0;
			func_q   <= '0;
			sum_q    <= '0;
			tail_q   <= '0;
		end else if (adv) begin
			if (last_in) begin
				pos_q    <= '0;
				hdr_ok_q <= 1'b0;
				func_q   <= '0;
				sum_q    <= '0;
				tail_q   <= '0;
			end else begin
				pos_q  <= pos_nxt;
				sum_q  <= trk.sum_nxt;
				tail_q <= trk.tail_nxt;
				if (pos_q == POS_W'(0)) begin
					hdr_ok_q <= (data_in == HDR0);
				end else if (pos_q == POS_W'(1)) begin
					hdr_ok_q <= hdr_ok_q && (data_in == HDR1);
				end else if (pos_q == POS_W'(2)) begin
					func_q <= data_in;
				end
			end
		end
	end

	// channel bytes arrive high byte first
	always_ff @(posedge clk) begin
		for (int k = 0; k < HELD_DEPTH; k++) begin
			if (adv && chan_wr && chan_idx == (POS_W-1)'(k)) begin
				if (chan_off[0]) begin
					staged_q[k][7:0] <= data_in;
				end else begin
					staged_q[k][15:8] <= data_in;
				end
			end
		end
	end

endmodule

[hw/rtl/rcfp_result.sv]
module rcfp_result import rcfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  trk_t                   trk,
	input  chan_arr_t              staged,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [OUT_TDATA_W-1:0] out_data
);

	status_t   status;
	status_t   status_q;
	chan_arr_t held_q;
	logic      valid_q;

	always_comb begin
		if (trk.pos < POS_W'(MIN_LEN - 1)) begin
			status = STAT_TOO_SHORT;
		end else if (!trk.hdr_ok) begin
			status = STAT_BAD_HEADER;
		end else if (trk.sum_nxt != trk.tail_nxt) begin
			status = STAT_BAD_SUM;
		end else if (trk.func != FUNC_RC) begin
			status = STAT_OTHER_FUNC;
		end else if (trk.pos < POS_W'(MIN_RC_LEN - 1)) begin
			status = STAT_TOO_SHORT;
		end else begin
			status = STAT_UPDATED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			held_q   <= '0;
			status_q <= STAT_UPDATED;
		end else begin
			if (fire) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (fire) begin
				status_q <= status;
			end
			if (fire && status == STAT_UPDATED) begin
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					held_q[k] <= staged[k];
				end
			end
		end
	end

	always_comb begin
		out_data      = '0;
		out_data[2:0] = status_q;
		for (int k = 0; k < HELD_DEPTH; k++) begin
			out_data[3 + k * CHAN_W +: CHAN_W] = held_q[k];
		end
	end

	assign out_valid = valid_q;

endmodule

[hw/rtl/rc_frame_parser_core.sv]
// radio control frame parser
// s_axis takes one frame byte per transaction, tlast on the final byte.
// a frame opens with 0xaa 0xaf, byte 2 is the function code and the last
// four bytes hold the big-endian 32-bit sum of all earlier bytes.
// at each tlast one transaction leaves on m_axis: status and the ten held
// channels; function 0x03 frames that pass every check replace them.
// one byte is taken every cycle while no tlast byte is held back; a
// frame's last byte passes the input register and then the result
// register before its result shows on m_axis.
// while a result waits, bytes that do not end a frame keep flowing; a
// further tlast byte holds in the input register until the result goes.
// reset clears the frame state and the held channels to zero.
module rc_frame_parser_core import rcfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // in_byte
	input  logic                   s_axis_tlast,  // last_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// frame_status, throttle, yaw_stick, roll_stick, pitch_stick,
	// aux_one .. aux_six, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

`include "rc_frame_parser_core_assert.svh"

	logic [7:0] data_s1;
	logic       last_s1;
	logic       valid_s1;
	logic       adv;
	logic       s_fire;
	trk_t       trk;
	chan_arr_t  staged;

	assign adv           = valid_s1 && (!last_s1 || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	rcfp_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.data_in (data_s1),
		.last_in (last_s1),
		.trk     (trk),
		.staged  (staged)
	);

	rcfp_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv && last_s1),
		.trk       (trk),
		.staged    (staged),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

	`RCFP_ASSERT_NEXT(a_frame_end_gives_result, adv && last_s1, m_axis_tvalid,
		"frame end without result")
	`RCFP_ASSERT_NEXT(a_no_spurious_result, adv && !last_s1 && !m_axis_tvalid,
		!m_axis_tvalid, "result without frame end")
	`RCFP_ASSERT_NEXT(a_result_changes_at_end, !(adv && last_s1), $stable(m_axis_tdata),
		"result data changed outside frame end")
	`RCFP_ASSERT_NEXT(a_pos_cleared_at_end, adv && last_s1, trk.pos == '0,
		"byte position not cleared at frame end")

endmodule

[tb/sv/rc_frame_parser_checker.sv]
`timescale 1ns / 100ps

module rc_frame_parser_checker import rcfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // in_byte
	input  logic                   s_axis_tlast,  // last_byte
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// frame_status, throttle, yaw_stick, roll_stick, pitch_stick,
	// aux_one .. aux_six, zero fill
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output int                     mismatches,
	output int                     reports_due
);

	typedef struct packed {
		status_t   status;
		chan_arr_t chans;
	} rc_report_t;

	string chan_name [HELD_DEPTH] = '{"throttle", "yaw_stick", "roll_stick", "pitch_stick",
		"aux_one", "aux_two", "aux_three", "aux_four", "aux_five", "aux_six"};

	logic [POS_W-1:0]  frame_pos;
	logic              hdr_seen_ok;
	logic [7:0]        func_byte;
	logic [31:0]       byte_sum;
	logic [31:0]       last_four;
	logic [CHAN_W-1:0] chan_stage [HELD_DEPTH];
	chan_arr_t         chan_held;
	rc_report_t        report_q [$];

	task automatic clear_frame_state();
		frame_pos   = '0;
		hdr_seen_ok = 1'b0;
		func_byte   = '0;
		byte_sum    = '0;
		last_four   = '0;
	endtask

	task automatic note_miss(input string field, input logic [15:0] want, input logic [15:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch %s: expected %h, got %h", field, want, got);
		end
	endtask

	task automatic take_byte(input logic [7:0] b, input logic fin);
		int         frame_len;
		int         ofs;
		rc_report_t rep;
		if (frame_pos == 0) begin
			hdr_seen_ok = (b == HDR0);
		end else if (frame_pos == 1) begin
			hdr_seen_ok = hdr_seen_ok && (b == HDR1);
		end else if (frame_pos == 2) begin
			func_byte = b;
		end
		ofs = int'(frame_pos) - CHAN_BASE;
		if (ofs >= 0 && ofs < 2 * NUM_CHANNELS) begin
			if (ofs % 2 == 0) begin
				chan_stage[ofs / 2][15:8] = b;
			end else begin
				chan_stage[ofs / 2][7:0] = b;
			end
		end
		if (ofs >= 0) begin
			byte_sum = byte_sum + 32'(last_four[31:24]);
		end
		last_four = {last_four[23:0], b};
		frame_len = int'(frame_pos) + 1;
		frame_pos = (frame_len < MAX_FRAME_LEN) ? POS_W'(frame_len) : POS_W'(MAX_FRAME_LEN);
		if (fin) begin
			if (frame_len < MIN_LEN) begin
				rep.status = STAT_TOO_SHORT;
			end else if (!hdr_seen_ok) begin
				rep.status = STAT_BAD_HEADER;
			end else if (byte_sum != last_four) begin
				rep.status = STAT_BAD_SUM;
			end else if (func_byte != FUNC_RC) begin
				rep.status = STAT_OTHER_FUNC;
			end else if (frame_len < MIN_RC_LEN) begin
				rep.status = STAT_TOO_SHORT;
			end else begin
				rep.status = STAT_UPDATED;
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					chan_held[k] = chan_stage[k];
				end
			end
			rep.chans = chan_held;
			report_q.push_back(rep);
			clear_frame_state();
		end
	endtask

	task automatic check_report(input logic [OUT_TDATA_W-1:0] d);
		rc_report_t want;
		if (report_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("report transaction with none pending: %h", d);
			end
		end else begin
			want = report_q.pop_front();
			if (d[2:0] !== want.status) begin
				note_miss("frame_status", 16'(want.status), 16'(d[2:0]));
			end
			for (int k = 0; k < HELD_DEPTH; k++) begin
				if (d[3 + k * CHAN_W +: CHAN_W] !== want.chans[k]) begin
					note_miss(chan_name[k], want.chans[k], d[3 + k * CHAN_W +: CHAN_W]);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame_state();
			for (int k = 0; k < HELD_DEPTH; k++) begin
				chan_stage[k] = '0;
			end
			chan_held = '0;
			report_q.delete();
			mismatches  = 0;
			reports_due = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				take_byte(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_report(m_axis_tdata);
			end
			reports_due = report_q.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top import rcfp_pkg::*;;

	localparam int RANDOM_BYTES = 260;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 4000;

	typedef enum int {
		FR_RC,
		FR_RC_SHORT,
		FR_RC_LONG,
		FR_OTHER_FUNC,
		FR_BAD_FIRST,
		FR_BAD_SECOND,
		FR_BAD_SUM,
		FR_SHORT,
		FR_NOISE
	} frame_kind_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata  = '0;  // in_byte
	logic                   s_axis_tlast  = 1'b0;  // last_byte
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// frame_status, throttle, yaw_stick, roll_stick, pitch_stick,
	// aux_one .. aux_six, zero fill
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int         mismatches;
	int         reports_due;
	int         hold_req   = 0;
	int         hold_done  = 0;
	int         stall_cnt  = 0;
	bit         quiet      = 1'b0;
	logic [7:0] frame_buf [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rc_frame_parser_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	rc_frame_parser_checker i_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.reports_due   (reports_due)
	);

	// receiver side
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = hold_req;
			end else if (quiet) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= 20);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cnt <= 0;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
			if (stall_cnt >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic void build_frame(input frame_kind_t kind, input int flen, input int fill);
		logic [31:0] csum;
		logic [7:0]  fb;
		csum = '0;
		frame_buf.delete();
		if (kind == FR_SHORT || kind == FR_NOISE) begin
			for (int k = 0; k < flen; k++) begin
				frame_buf.push_back(8'($urandom));
			end
			if (flen >= 2 && $urandom_range(0, 1) == 1) begin
				frame_buf[0] = HDR0;
				frame_buf[1] = HDR1;
			end
			return;
		end
		for (int k = 0; k < flen - 4; k++) begin
			frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
		end
		frame_buf[0] = HDR0;
		frame_buf[1] = HDR1;
		if (frame_buf.size() > 2) begin
			if (kind == FR_OTHER_FUNC || (kind == FR_BAD_SUM && $urandom_range(0, 1) == 1)) begin
				do begin
					fb = 8'($urandom);
				end while (fb == FUNC_RC);
				frame_buf[2] = fb;
			end else begin
				frame_buf[2] = FUNC_RC;
			end
		end
		if (kind == FR_BAD_FIRST) begin
			frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
		end else if (kind == FR_BAD_SECOND) begin
			frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(1, 255));
		end
		foreach (frame_buf[k]) begin
			csum = csum + 32'(frame_buf[k]);
		end
		frame_buf.push_back(csum[31:24]);
		frame_buf.push_back(csum[23:16]);
		frame_buf.push_back(csum[15:8]);
		frame_buf.push_back(csum[7:0]);
		if (kind == FR_BAD_SUM) begin
			fb = 8'(1 << $urandom_range(0, 7));
			frame_buf[flen - 1 - $urandom_range(0, 3)] ^= fb;
		end
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic fin);
		while (!quiet && $urandom_range(0, 99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_frame(input frame_kind_t kind, input int flen, input int fill);
		build_frame(kind, flen, fill);
		foreach (frame_buf[k]) begin
			put_byte(frame_buf[k], k == frame_buf.size() - 1);
		end
	endtask

	// wait for the falling edge so the count from the last accepting edge is settled
	task automatic drain_reports();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		wait (reports_due == 0);
		@(posedge clk);
	endtask

	initial begin
		int sent_bytes;
		int frames;
		int pick;
		sent_bytes = 0;
		frames     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(FR_RC, 28, 8'hFF);
		send_frame(FR_RC, 28, 8'h00);
		send_frame(FR_RC, 28, -1);
		send_frame(FR_OTHER_FUNC, 28, -1);
		send_frame(FR_BAD_FIRST, 28, -1);
		send_frame(FR_BAD_SECOND, 28, -1);
		send_frame(FR_BAD_SUM, 28, -1);
		send_frame(FR_SHORT, 1, -1);
		send_frame(FR_SHORT, 5, -1);
		send_frame(FR_RC_SHORT, 27, -1);
		send_frame(FR_RC_SHORT, 7, -1);
		send_frame(FR_OTHER_FUNC, 6, -1);
		send_frame(FR_RC, 33, -1);
		send_frame(FR_RC_LONG, 300, -1);
		send_frame(FR_NOISE, 20, -1);
		drain_reports();

		// long receiver stall with back-to-back short frames
		hold_req++;
		repeat (12) begin
			send_frame(FR_SHORT, $urandom_range(1, 5), -1);
		end
		send_frame(FR_RC, 28, -1);

		while (sent_bytes < RANDOM_BYTES || frames < 8) begin
			quiet = (sent_bytes >= 60 && sent_bytes < 180);
			pick  = $urandom_range(0, 99);
			if (pick < 40) begin
				send_frame(FR_RC, ($urandom_range(0, 3) == 0) ? $urandom_range(29, 40) : 28, -1);
			end else if (pick < 48) begin
				send_frame(FR_RC_SHORT, $urandom_range(7, 27), -1);
			end else if (pick < 58) begin
				send_frame(FR_OTHER_FUNC, $urandom_range(6, 40), -1);
			end else if (pick < 64) begin
				send_frame(FR_BAD_FIRST, $urandom_range(6, 40), -1);
			end else if (pick < 70) begin
				send_frame(FR_BAD_SECOND, $urandom_range(6, 40), -1);
			end else if (pick < 80) begin
				send_frame(FR_BAD_SUM, $urandom_range(6, 40), -1);
			end else if (pick < 90) begin
				send_frame(FR_SHORT, $urandom_range(1, 5), -1);
			end else if (pick < 98) begin
				send_frame(FR_NOISE, $urandom_range(1, 40), -1);
			end else begin
				send_frame(FR_RC_LONG, $urandom_range(256, 300), -1);
			end
			sent_bytes += frame_buf.size();
			frames++;
		end
		quiet = 1'b0;

		drain_reports();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && reports_due == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
